### rtl/rrts_pkg.sv
// Package for the round-robin task scheduler.
// Holds the shared widths, codes, slot record type and reset defaults.
// It has no dependencies.
package rrts_pkg;

  // Default number of task slots.
  localparam int SlotCountDef = 16;

  // Field widths.
  localparam int OpW    = 3;
  localparam int TimeW  = 64;
  localparam int MsW    = 32;
  localparam int IdW    = 32;
  localparam int QntW   = 16;
  localparam int RateW  = 17;
  localparam int StatW  = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW   = 17;

  // Milliseconds per second, used in the sleep conversion.
  localparam int TickDiv = 1000;

  // Register reset values.
  localparam logic [QntW-1:0]  QuantumReset = 16'd10;
  localparam logic [RateW-1:0] RateReset    = 17'd1000;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_YIELD  = 3'd1,
    OP_CREATE = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_EXIT   = 3'd4,
    OP_KILL   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_DEAD     = 3'd4
  } slot_status_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_TASK  = 2'd2,
    STAT_DISABLED = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUANTUM = 2'd0,
    CFG_RATE    = 2'd1,
    CFG_ENABLE  = 2'd2
  } cfg_idx_e;

  // One entry of the slot table, as it travels along the ring.
  typedef struct packed {
    slot_status_e       status;
    logic [IdW-1:0]     id;
    logic [TimeW-1:0]   wake;
  } slot_t;

endpackage

### rtl/rrts_if.sv
// Handshake interfaces of the task scheduler: request channel and result channel.
// Depends on rrts_pkg for field widths.
interface rrts_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::OpW-1:0]    operation;
  logic [rrts_pkg::TimeW-1:0]  current_time;
  logic [rrts_pkg::MsW-1:0]    sleep_ms;
  logic [rrts_pkg::IdW-1:0]    target_id;

  modport source (output valid, operation, current_time, sleep_ms, target_id, input ready);
  modport sink   (input valid, operation, current_time, sleep_ms, target_id, output ready);
endinterface

interface rrts_out_if #(
  parameter int SLOT_COUNT = rrts_pkg::SlotCountDef
);
  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int CntW = $clog2(SLOT_COUNT + 1);

  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::StatW-1:0]  status;
  logic                        switched;
  logic [IdxW-1:0]             running_slot;
  logic [rrts_pkg::IdW-1:0]    running_id;
  logic [rrts_pkg::IdW-1:0]    new_id;
  logic [CntW-1:0]             runnable_count;

  modport source (output valid, status, switched, running_slot, running_id, new_id,
                  runnable_count, input ready);
  modport sink   (input valid, status, switched, running_slot, running_id, new_id,
                  runnable_count, output ready);
endinterface

### rtl/rrts_cell.sv
// One cell of the slot ring: holds one slot record and passes it on when shifting.
// Depends on rrts_pkg for the slot record type.
module rrts_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  rrts_pkg::slot_t d_i,
  output rrts_pkg::slot_t q_o
);

  rrts_pkg::slot_t slot_q;

  // The first cell starts as the running task, all others as unused.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.status <= FIRST ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_UNUSED;
      slot_q.id     <= '0;
      slot_q.wake   <= '0;
    end else if (shift_i) begin
      slot_q <= d_i;
    end
  end

  assign q_o = slot_q;

endmodule

### rtl/rrts_tick_conv.sv
// Sleep conversion unit: ticks = ms * rate / 1000, at least one tick for nonzero ms.
// One registered multiply, then a divide by 1000 in four 16-bit quotient digits,
// each found by a reciprocal multiplication. Depends on rrts_pkg.
module rrts_tick_conv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rrts_pkg::MsW-1:0]    ms_i,
  input  logic [rrts_pkg::RateW-1:0]  rate_i,
  output logic                        done_o,
  output logic [rrts_pkg::TimeW-1:0]  ticks_o
);

  localparam int ProdW   = rrts_pkg::MsW + rrts_pkg::RateW;
  localparam int DigW    = 16;
  localparam int RemW    = 10;
  localparam int PartW   = RemW + DigW;
  localparam int RecipW  = 27;
  localparam int RecipSh = 36;
  localparam int WideW   = PartW + RecipW;
  localparam logic [RecipW-1:0] Recip    = 27'd68719477;
  localparam logic [PartW-1:0]  Div      = PartW'(rrts_pkg::TickDiv);
  localparam logic [1:0]        LastStep = 2'd3;

  logic                       busy_q, done_q, ms_nz_q;
  logic [1:0]                 step_q;
  logic [RemW-1:0]            rem_q;
  logic [rrts_pkg::TimeW-1:0] dq_q;
  logic [ProdW-1:0]           prod;
  logic [PartW-1:0]           part, back, rest;
  logic [WideW-1:0]           wide;
  logic [DigW-1:0]            qdig;

  // Product of milliseconds and rate, loaded when a conversion starts.
  assign prod = ProdW'(ms_i) * ProdW'(rate_i);

  // One quotient digit per cycle. The partial dividend stays below 1000 * 2^16, where
  // multiplying by 2^36 / 1000 rounded up and dropping 36 bits gives the exact quotient.
  assign part = {rem_q, dq_q[rrts_pkg::TimeW-1 -: DigW]};
  assign wide = WideW'(part) * WideW'(Recip);
  assign qdig = wide[RecipSh +: DigW];
  assign back = PartW'(qdig) * Div;
  assign rest = part - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers: the dividend shifts out at the top as quotient digits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q    <= rrts_pkg::TimeW'(prod);
      rem_q   <= '0;
      ms_nz_q <= ms_i != '0;
    end else if (busy_q) begin
      rem_q <= rest[RemW-1:0];
      dq_q  <= {dq_q[rrts_pkg::TimeW-DigW-1:0], qdig};
    end
  end

  assign done_o  = done_q;
  assign ticks_o = (ms_nz_q && dq_q == '0) ? rrts_pkg::TimeW'(1) : dq_q;

endmodule

### rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: a ring of slot cells and its controller.
// Depends on rrts_pkg, rrts_if, rrts_cell and rrts_tick_conv.
//
//   Channel   Dir  Handshake          Carries
//   in_if     in   valid/ready        operation, current_time, sleep_ms, target_id
//   out_if    out  valid/ready        status, switched, running_slot/id, new_id, count
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (no read-back)
//
// The result is offered once the ring has rotated once to update the table, the
// controller has passed its decide state and the ring has rotated once more to apply
// the task switch; the next request can be taken once the result is loaded.
// A sleep first runs the multiply and four-digit divide by 1000 in state S_CONV.
// Reset is asynchronous; the table is reset in place, with no clearing pass.
// One item is in flight at a time; a result not yet taken stalls the next one.
module round_robin_task_scheduler #(
  parameter int SLOT_COUNT = rrts_pkg::SlotCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rrts_pkg::CfgW-1:0]     cfg_data_i,
  rrts_in_if.sink                       in_if,
  rrts_out_if.source                    out_if
);

  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);
  localparam logic [CntW-1:0] SlotCnt = CntW'(SLOT_COUNT);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CONV   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_APPLY  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [rrts_pkg::QntW-1:0]  quantum_q;
  logic [rrts_pkg::RateW-1:0] rate_q;
  logic                       enable_q;

  // Latched request.
  rrts_pkg::op_e               op_q;
  logic                        op_ok_q, dis_q;
  logic [rrts_pkg::TimeW-1:0]  now_q, ticks_q;
  logic [rrts_pkg::MsW-1:0]    ms_q;
  logic [rrts_pkg::IdW-1:0]    target_q;

  // Scheduler state outside the table.
  logic [IdxW-1:0]            cur_q, old_q;
  logic [CntW-1:0]            used_q;
  logic [rrts_pkg::IdW-1:0]   idc_q;
  logic [rrts_pkg::QntW-1:0]  qc_q;

  // Scan bookkeeping.
  logic [IdxW-1:0]  pos_q, found_slot_q, hi_q, lo_q;
  logic             found_q, hi_v_q, lo_v_q, sw_q;
  logic [CntW-1:0]  cnt_q;
  logic [rrts_pkg::IdW-1:0] rid_q, new_id_q;
  rrts_pkg::status_e        res_status_q;

  // Output register.
  logic                       out_valid_q, out_sw_q;
  rrts_pkg::status_e          out_status_q;
  logic [IdxW-1:0]            out_slot_q;
  logic [rrts_pkg::IdW-1:0]   out_rid_q, out_new_id_q;
  logic [CntW-1:0]            out_cnt_q;

  // Ring of cells.
  rrts_pkg::slot_t cell_q [SLOT_COUNT];
  rrts_pkg::slot_t tail_d;
  logic            shift;

  logic in_acc, conv_start, conv_done, load_out;
  logic [rrts_pkg::TimeW-1:0] conv_ticks;

  assign in_acc   = in_if.valid && in_if.ready;
  assign shift    = (state_q == S_SCAN) || (state_q == S_APPLY);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_if.ready);
  assign conv_start = in_acc && enable_q &&
                      (rrts_pkg::op_e'(in_if.operation) == rrts_pkg::OP_SLEEP);

  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_ring
    rrts_pkg::slot_t d;
    if (k == SLOT_COUNT - 1) begin : g_tail
      assign d = tail_d;
    end else begin : g_mid
      assign d = cell_q[k+1];
    end
    rrts_cell #(.FIRST(k == 0)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .d_i    (d),
      .q_o    (cell_q[k])
    );
  end

  rrts_tick_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(conv_start),
    .ms_i   (in_if.sleep_ms),
    .rate_i (rate_q),
    .done_o (conv_done),
    .ticks_o(conv_ticks)
  );

  // Per-slot update of the record at the head of the ring.
  logic head_hit, head_lt_used, head_is_cur, head_run;
  always_comb begin
    tail_d       = cell_q[0];
    head_hit     = 1'b0;
    head_lt_used = CntW'(pos_q) < used_q;
    head_is_cur  = pos_q == cur_q;
    if (state_q == S_SCAN && op_ok_q) begin
      case (op_q)
        rrts_pkg::OP_TICK: begin
          if (head_lt_used && cell_q[0].status == rrts_pkg::ST_SLEEPING &&
              now_q >= cell_q[0].wake) begin
            tail_d.status = head_is_cur ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_READY;
          end
        end
        rrts_pkg::OP_SLEEP: begin
          if (head_is_cur) begin
            tail_d.status = rrts_pkg::ST_SLEEPING;
            tail_d.wake   = now_q + ticks_q;
          end
        end
        rrts_pkg::OP_EXIT: begin
          if (head_is_cur) tail_d.status = rrts_pkg::ST_DEAD;
        end
        rrts_pkg::OP_KILL: begin
          if (!found_q && target_q != '0 && pos_q != '0 && head_lt_used &&
              cell_q[0].id == target_q && cell_q[0].status != rrts_pkg::ST_DEAD) begin
            tail_d.status = rrts_pkg::ST_DEAD;
            head_hit      = 1'b1;
          end
        end
        rrts_pkg::OP_CREATE: begin
          if (!found_q && used_q < SlotCnt &&
              (cell_q[0].status == rrts_pkg::ST_DEAD ||
               (!head_lt_used && cell_q[0].status == rrts_pkg::ST_UNUSED))) begin
            tail_d.status = rrts_pkg::ST_READY;
            tail_d.id     = idc_q;
            head_hit      = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_APPLY && sw_q) begin
      if (pos_q == old_q && cell_q[0].status == rrts_pkg::ST_RUNNING)
        tail_d.status = rrts_pkg::ST_READY;
      if (head_is_cur) tail_d.status = rrts_pkg::ST_RUNNING;
    end
    head_run = tail_d.status == rrts_pkg::ST_READY ||
               tail_d.status == rrts_pkg::ST_RUNNING;
  end

  // Scheduling decision at the end of the update pass.
  logic                       forced, step_req, do_step, sw_d;
  logic [rrts_pkg::QntW-1:0]  qc_in, qc_inc;
  logic [IdxW-1:0]            nxt;
  always_comb begin
    forced   = op_q == rrts_pkg::OP_YIELD || op_q == rrts_pkg::OP_SLEEP ||
               op_q == rrts_pkg::OP_EXIT;
    step_req = op_ok_q && (forced || op_q == rrts_pkg::OP_TICK ||
               (op_q == rrts_pkg::OP_KILL && found_q && found_slot_q == cur_q));
    do_step  = step_req && used_q > CntW'(1);
    qc_in    = forced ? quantum_q : qc_q;
    qc_inc   = (qc_in != '1) ? qc_in + 1'b1 : qc_in;
    nxt      = hi_v_q ? hi_q : lo_q;
    sw_d     = do_step && qc_inc >= quantum_q && (hi_v_q || lo_v_q) && nxt != cur_q;
  end

  // Controller state machine.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = conv_start ? S_CONV : S_SCAN;
      S_CONV:   if (conv_done) state_d = S_SCAN;
      S_SCAN:   if (pos_q == LastIdx) state_d = S_DECIDE;
      S_DECIDE: state_d = S_APPLY;
      S_APPLY:  if (pos_q == LastIdx) state_d = S_DONE;
      S_DONE:   if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      quantum_q   <= rrts_pkg::QuantumReset;
      rate_q      <= rrts_pkg::RateReset;
      enable_q    <= 1'b1;
      cur_q       <= '0;
      used_q      <= CntW'(1);
      idc_q       <= rrts_pkg::IdW'(1);
      qc_q        <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      hi_v_q      <= 1'b0;
      lo_v_q      <= 1'b0;
      sw_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Configuration writes.
      if (cfg_we_i) begin
        unique case (rrts_pkg::cfg_idx_e'(cfg_idx_i))
          rrts_pkg::CFG_QUANTUM: quantum_q <= cfg_data_i[rrts_pkg::QntW-1:0];
          rrts_pkg::CFG_RATE:    rate_q    <= cfg_data_i[rrts_pkg::RateW-1:0];
          rrts_pkg::CFG_ENABLE:  enable_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_acc) begin
        pos_q   <= '0;
        found_q <= 1'b0;
        hi_v_q  <= 1'b0;
        lo_v_q  <= 1'b0;
      end

      // Update pass: first-match searches and candidate tracking.
      if (state_q == S_SCAN) begin
        pos_q <= (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
        if (head_hit) found_q <= 1'b1;
        if (head_run && head_lt_used) begin
          if (pos_q > cur_q && !hi_v_q) hi_v_q <= 1'b1;
          if (pos_q <= cur_q && !lo_v_q) lo_v_q <= 1'b1;
        end
      end

      if (state_q == S_DECIDE) begin
        sw_q <= sw_d;
        if (sw_d) cur_q <= nxt;
        if (do_step) qc_q <= (qc_inc < quantum_q) ? qc_inc : '0;
        if (op_ok_q && op_q == rrts_pkg::OP_CREATE && found_q) begin
          idc_q <= idc_q + 1'b1;
          if (CntW'(found_slot_q) >= used_q) used_q <= CntW'(found_slot_q) + 1'b1;
        end
      end

      if (state_q == S_APPLY)
        pos_q <= (pos_q == LastIdx) ? '0 : pos_q + 1'b1;

      if (load_out) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= rrts_pkg::op_e'(in_if.operation);
      op_ok_q  <= enable_q && in_if.operation <= rrts_pkg::OpW'(rrts_pkg::OP_KILL);
      dis_q    <= !enable_q;
      now_q    <= in_if.current_time;
      ms_q     <= in_if.sleep_ms;
      target_q <= in_if.target_id;
      cnt_q    <= '0;
    end
    if (state_q == S_CONV && conv_done) ticks_q <= (ms_q == '0) ? '0 : conv_ticks;
    if (state_q == S_SCAN) begin
      if (head_hit) found_slot_q <= pos_q;
      if (head_run) cnt_q <= cnt_q + 1'b1;
      if (head_run && head_lt_used) begin
        if (pos_q > cur_q && !hi_v_q) hi_q <= pos_q;
        if (pos_q <= cur_q && !lo_v_q) lo_q <= pos_q;
      end
    end
    if (state_q == S_DECIDE) begin
      old_q    <= cur_q;
      new_id_q <= (op_ok_q && op_q == rrts_pkg::OP_CREATE && found_q) ? idc_q : '0;
      if (dis_q) res_status_q <= rrts_pkg::STAT_DISABLED;
      else if (op_ok_q && op_q == rrts_pkg::OP_CREATE && !found_q)
        res_status_q <= rrts_pkg::STAT_FULL;
      else if (op_ok_q && op_q == rrts_pkg::OP_KILL && !found_q)
        res_status_q <= rrts_pkg::STAT_NO_TASK;
      else res_status_q <= rrts_pkg::STAT_OK;
    end
    if (state_q == S_APPLY && head_is_cur) rid_q <= tail_d.id;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_sw_q     <= cur_q != old_q;
      out_slot_q   <= cur_q;
      out_rid_q    <= rid_q;
      out_new_id_q <= new_id_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign in_if.ready           = state_q == S_IDLE;
  assign out_if.valid          = out_valid_q;
  assign out_if.status         = out_status_q;
  assign out_if.switched       = out_sw_q;
  assign out_if.running_slot   = out_slot_q;
  assign out_if.running_id     = out_rid_q;
  assign out_if.new_id         = out_new_id_q;
  assign out_if.runnable_count = out_cnt_q;

endmodule

### rtl/rrts_checker.sv
// Port-level checks for the task scheduler, attached to the top level by bind.
// Depends on rrts_pkg and round_robin_task_scheduler.
module rrts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rrts_pkg::StatW-1:0] out_status,
  input logic                       out_switched,
  input logic [rrts_pkg::IdW-1:0]   out_new_id
);

  // One transaction in flight: ready drops right after an accepted request.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another was in flight");

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A disabled scheduler neither switches nor hands out identifiers.
  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status == rrts_pkg::STAT_DISABLED |-> !out_switched && out_new_id == '0)
    else $error("disabled result shows a state change");

  // A new identifier comes only from a successful create, which never switches.
  a_create_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_new_id != '0 |-> out_status == rrts_pkg::STAT_OK && !out_switched)
    else $error("new identifier on a result that is not a create");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_status  (out_if.status),
  .out_switched(out_if.switched),
  .out_new_id  (out_if.new_id)
);
